// ----- rtl/ksab_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksab_pkg: shared types and constants of the key state and action binder
// Request and result layouts, opcodes, status codes and the modifier match.
// ----------------------------------------------------------------------------
package ksab_pkg;

    localparam int OPCODE_W = 3;
    localparam int KEY_W    = 9;
    localparam int ACTION_W = 6;
    localparam int SLOT_W   = 2;
    localparam int MOD_W    = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    // request opcodes
    typedef enum logic [OPCODE_W-1:0] {
        OP_KEY_EVENT = 3'd0,
        OP_FRAME_END = 3'd1,
        OP_BIND      = 3'd2,
        OP_REBIND    = 3'd3,
        OP_SET_SLOT  = 3'd4,
        OP_UNBIND    = 3'd5,
        OP_QUERY     = 3'd6
    } opcode_t;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ACTION = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_KEY_ZERO   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GUI   = 2'd3;

    localparam logic [MOD_W-1:0] CTRL_MASK_RST  = 16'h00C0;
    localparam logic [MOD_W-1:0] SHIFT_MASK_RST = 16'h0003;
    localparam logic [MOD_W-1:0] ALT_MASK_RST   = 16'h0300;
    localparam logic [MOD_W-1:0] GUI_MASK_RST   = 16'h0C00;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCAN,
        S_FRAME,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [KEY_W-1:0]    key;
        logic                key_down;
        logic [MOD_W-1:0]    event_modifiers;
        logic [ACTION_W-1:0] action;
        logic [SLOT_W-1:0]   slot;
        logic [MOD_W-1:0]    binding_modifiers;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                key_is_pressed;
        logic                key_was_just_pressed;
        logic                key_was_just_released;
        logic                action_is_bound;
        logic                action_is_pressed;
        logic                action_just_pressed;
        logic                action_just_released;
        logic [KEY_W-1:0]    slot_key;
        logic [MOD_W-1:0]    slot_modifiers;
        logic [MOD_W-1:0]    modifiers_now;
    } out_item_t;

    // Each group: nothing asked means no bit of the group may be held,
    // otherwise at least one asked bit must be held.
    function automatic logic mod_match(
        input logic [3:0][MOD_W-1:0] masks,
        input logic [MOD_W-1:0]      required,
        input logic [MOD_W-1:0]      held
    );
        logic             ok;
        logic [MOD_W-1:0] wanted;
        logic [MOD_W-1:0] have;
        ok = 1'b1;
        for (int g = 0; g < 4; g++) begin
            wanted = required & masks[g];
            have   = held & masks[g];
            if (wanted == '0) begin
                if (have != '0) ok = 1'b0;
            end else if ((have & wanted) == '0) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

// ----- rtl/ksab_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksab_if: request and result channels
// Valid/ready channels carrying one request or one result per handshake.
// ----------------------------------------------------------------------------
interface ksab_item_if;
    logic                valid;
    logic                ready;
    ksab_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ksab_result_if;
    logic                valid;
    logic                ready;
    ksab_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ksab_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksab_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module ksab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ksab_row_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksab_row_update: new contents of one action's binding row
// Bind reuses a slot with the same key, else the first free one, else the
// last; rebind starts from an empty row; set writes one slot; unbind clears.
// ----------------------------------------------------------------------------
module ksab_row_update #(
    parameter int SLOTS = 4,
    parameter int MOD_W = 16
) (
    input  logic [ksab_pkg::OPCODE_W-1:0]      op,
    input  logic [ksab_pkg::KEY_W-1:0]         key,
    input  logic [MOD_W-1:0]                   mods,
    input  logic [ksab_pkg::SLOT_W-1:0]        slot,
    input  logic [SLOTS-1:0][ksab_pkg::KEY_W-1:0] cur_key,
    input  logic [SLOTS-1:0][MOD_W-1:0]        cur_mod,
    output logic [SLOTS-1:0][ksab_pkg::KEY_W-1:0] new_key,
    output logic [SLOTS-1:0][MOD_W-1:0]        new_mod
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic          hit;
    logic          free;
    logic [SW-1:0] hit_idx;
    logic [SW-1:0] free_idx;
    logic [SW-1:0] tgt_idx;

    // slot search for bind
    always_comb
    begin
        hit      = 1'b0;
        free     = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!hit && cur_key[i] == key)
            begin
                hit     = 1'b1;
                hit_idx = SW'(i);
            end
            if (!free && cur_key[i] == '0)
            begin
                free     = 1'b1;
                free_idx = SW'(i);
            end
        end
        if (hit)
            tgt_idx = hit_idx;
        else if (free)
            tgt_idx = free_idx;
        else
            tgt_idx = SW'(SLOTS - 1);
    end

    // row contents per operation
    always_comb
    begin
        new_key = cur_key;
        new_mod = cur_mod;
        unique case (op) inside
            ksab_pkg::OP_BIND:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (SW'(i) == tgt_idx)
                    begin
                        new_key[i] = key;
                        new_mod[i] = mods;
                    end
                end
            end
            ksab_pkg::OP_REBIND:
            begin
                new_key    = '0;
                new_mod    = '0;
                new_key[0] = key;
                new_mod[0] = mods;
            end
            ksab_pkg::OP_SET_SLOT:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (32'(slot) == i)
                    begin
                        new_key[i] = key;
                        new_mod[i] = (key == '0) ? '0 : mods;
                    end
                end
            end
            ksab_pkg::OP_UNBIND:
            begin
                new_key = '0;
                new_mod = '0;
            end
            default:
            begin
                new_key = cur_key;
                new_mod = cur_mod;
            end
        endcase
    end

endmodule

// ----- rtl/key_state_action_binder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_state_action_binder_core: per-key input state and action bindings
// Key flags live in one RAM (held, press edge, release edge per key), the
// binding table in another (one row of slots per action). Each request is a
// read, a modify and a write back (a query only reads); queries scan the slots of one row.
//
//   channel   | dir | handshake       | payload
//   ----------+-----+-----------------+--------------------------------
//   item      | in  | valid / ready   | ksab_pkg::in_item_t
//   result    | out | valid / ready   | ksab_pkg::out_item_t
//   cfg       | in  | cfg_we only     | cfg_index, cfg_wdata
//
// Key event, bind, rebind, set, unbind, query of an invalid action: a request
// passes accept, read-modify-write and emit; the result register loads in emit.
// Query of a valid action: accept, read, slot scan and emit, one key RAM read per slot.
// Frame end: accept, a read-modify-write sweep of the key RAM, then emit.
// After reset a clearing pass over max(KEY_COUNT, ACTION_COUNT) addresses runs
// before the first request is taken. A result waits in the output register
// while the next request is accepted; a stalled result holds the emit step.
// ----------------------------------------------------------------------------
module key_state_action_binder_core #(
    parameter int KEY_COUNT        = 512,
    parameter int ACTION_COUNT     = 64,
    parameter int SLOTS_PER_ACTION = 4,
    parameter int MODIFIER_BITS    = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    ksab_item_if.sink                      item,
    ksab_result_if.source                  result,
    input  logic                           cfg_we,
    input  logic [ksab_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ksab_pkg::MOD_W-1:0]     cfg_wdata
);

    localparam int KW      = ksab_pkg::KEY_W;
    localparam int MW      = MODIFIER_BITS;
    localparam int S       = SLOTS_PER_ACTION;
    localparam int SW      = (S > 1) ? $clog2(S) : 1;
    localparam int KA      = $clog2(KEY_COUNT);
    localparam int AA      = $clog2(ACTION_COUNT);
    localparam int ENT_W   = KW + MW;
    localparam int ROW_W   = S * ENT_W;
    localparam int MAXD    = (KEY_COUNT > ACTION_COUNT) ? KEY_COUNT : ACTION_COUNT;
    localparam int SWEEP_W = $clog2(MAXD + 1);

    // key flag bit positions
    localparam int F_HELD = 2;
    localparam int F_PRESS = 1;
    localparam int F_REL  = 0;

    ksab_pkg::state_t state_reg, state_next;

    logic [SWEEP_W-1:0]         sweep_reg, sweep_next;
    logic [SW-1:0]              scan_reg, scan_next;
    ksab_pkg::in_item_t         item_reg, item_next;
    ksab_pkg::out_item_t        res_reg, res_next;
    ksab_pkg::out_item_t        out_data_reg, out_data_next;
    logic                       out_valid_reg, out_valid_next;
    logic [MW-1:0]              cur_mod_reg, cur_mod_next;
    logic [3:0][ksab_pkg::MOD_W-1:0] mask_reg, mask_next;
    logic [S-1:0][KW-1:0]       row_key_reg, row_key_next;
    logic [S-1:0][MW-1:0]       row_mod_reg, row_mod_next;

    logic                       item_accept;

    // key RAM port signals
    logic                       kmem_we;
    logic [KA-1:0]              kmem_waddr;
    logic [2:0]                 kmem_wdata;
    logic [KA-1:0]              kmem_raddr;
    logic [2:0]                 kmem_rdata;

    // binding RAM port signals
    logic                       bmem_we;
    logic [AA-1:0]              bmem_waddr;
    logic [ROW_W-1:0]           bmem_wdata;
    logic [AA-1:0]              bmem_raddr;
    logic [ROW_W-1:0]           bmem_rdata;

    logic [S-1:0][KW-1:0]       rd_key;
    logic [S-1:0][MW-1:0]       rd_mod;
    logic [S-1:0][KW-1:0]       upd_key;
    logic [S-1:0][MW-1:0]       upd_mod;

    // decoded request conditions
    logic                       act_ok;
    logic                       slot_ok;
    logic                       row_we;
    logic [ksab_pkg::STATUS_W-1:0] status_c;
    logic                       emit_go;
    logic                       scan_last;
    logic [SW-1:0]              scan_inc;
    logic [KW-1:0]              scan_key;
    logic [MW-1:0]              scan_mod;

    function automatic logic key_ok(input logic [KW-1:0] k);
        return 32'(k) < 32'(KEY_COUNT);
    endfunction

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    ksab_ram #(
        .WIDTH (3),
        .DEPTH (KEY_COUNT)
    ) u_key_ram (
        .clk   (clk),
        .we    (kmem_we),
        .waddr (kmem_waddr),
        .wdata (kmem_wdata),
        .raddr (kmem_raddr),
        .rdata (kmem_rdata)
    );

    ksab_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ACTION_COUNT)
    ) u_bind_ram (
        .clk   (clk),
        .we    (bmem_we),
        .waddr (bmem_waddr),
        .wdata (bmem_wdata),
        .raddr (bmem_raddr),
        .rdata (bmem_rdata)
    );

    // row unpack / pack; the clearing pass writes empty rows
    always_comb
    begin
        bmem_wdata = '0;
        for (int i = 0; i < S; i++)
        begin
            rd_key[i] = bmem_rdata[i*ENT_W + MW +: KW];
            rd_mod[i] = bmem_rdata[i*ENT_W +: MW];
            bmem_wdata[i*ENT_W + MW +: KW] = upd_key[i];
            bmem_wdata[i*ENT_W +: MW]      = upd_mod[i];
        end
        if (state_reg == ksab_pkg::S_CLEAR)
            bmem_wdata = '0;
    end

    ksab_row_update #(
        .SLOTS (S),
        .MOD_W (MW)
    ) u_row_update (
        .op      (item_reg.opcode),
        .key     (item_reg.key),
        .mods    (MW'(item_reg.binding_modifiers)),
        .slot    (item_reg.slot),
        .cur_key (rd_key),
        .cur_mod (rd_mod),
        .new_key (upd_key),
        .new_mod (upd_mod)
    );

    // ------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------
    assign item_accept = item.valid & item.ready;
    assign item.ready  = (state_reg == ksab_pkg::S_IDLE);
    assign act_ok  = (item_reg.action != '0) && (32'(item_reg.action) < 32'(ACTION_COUNT));
    assign slot_ok = 32'(item_reg.slot) < 32'(S);
    assign emit_go = !out_valid_reg || result.ready;

    assign scan_last = (scan_reg == SW'(S - 1));
    assign scan_inc  = scan_last ? '0 : scan_reg + SW'(1);
    assign scan_key  = row_key_reg[scan_reg];
    assign scan_mod  = row_mod_reg[scan_reg];

    // status and binding write enable
    always_comb
    begin
        status_c = ksab_pkg::STATUS_OK;
        row_we   = 1'b0;
        case (item_reg.opcode) inside
            ksab_pkg::OP_BIND, ksab_pkg::OP_REBIND:
            begin
                if (item_reg.key == '0)
                    status_c = ksab_pkg::STATUS_KEY_ZERO;
                else if (!act_ok)
                    status_c = ksab_pkg::STATUS_BAD_ACTION;
                row_we = (item_reg.key != '0) && act_ok;
            end
            ksab_pkg::OP_SET_SLOT:
            begin
                if (slot_ok && !act_ok)
                    status_c = ksab_pkg::STATUS_BAD_ACTION;
                row_we = slot_ok && act_ok;
            end
            ksab_pkg::OP_UNBIND:
            begin
                if (!act_ok)
                    status_c = ksab_pkg::STATUS_BAD_ACTION;
                row_we = act_ok;
            end
            ksab_pkg::OP_QUERY:
            begin
                if (!act_ok)
                    status_c = ksab_pkg::STATUS_BAD_ACTION;
            end
            default:
            begin
                status_c = ksab_pkg::STATUS_OK;
                row_we   = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ksab_pkg::S_CLEAR:
            begin
                if (sweep_reg == SWEEP_W'(MAXD - 1))
                    state_next = ksab_pkg::S_IDLE;
            end
            ksab_pkg::S_IDLE:
            begin
                if (item_accept)
                begin
                    if (item.data.opcode == ksab_pkg::OP_FRAME_END)
                        state_next = ksab_pkg::S_FRAME;
                    else
                        state_next = ksab_pkg::S_READ;
                end
            end
            ksab_pkg::S_READ:
            begin
                if (item_reg.opcode == ksab_pkg::OP_QUERY && act_ok)
                    state_next = ksab_pkg::S_SCAN;
                else
                    state_next = ksab_pkg::S_EMIT;
            end
            ksab_pkg::S_SCAN:
            begin
                if (scan_last)
                    state_next = ksab_pkg::S_EMIT;
            end
            ksab_pkg::S_FRAME:
            begin
                if (sweep_reg == SWEEP_W'(KEY_COUNT))
                    state_next = ksab_pkg::S_EMIT;
            end
            ksab_pkg::S_EMIT:
            begin
                if (emit_go)
                    state_next = ksab_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ksab_pkg::S_CLEAR;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // datapath and memory control
    // ------------------------------------------------------------------
    always_comb
    begin
        item_next      = item_reg;
        res_next       = res_reg;
        row_key_next   = row_key_reg;
        row_mod_next   = row_mod_reg;
        sweep_next     = sweep_reg;
        scan_next      = scan_reg;
        cur_mod_next   = cur_mod_reg;
        out_valid_next = out_valid_reg & ~result.ready;
        out_data_next  = out_data_reg;

        kmem_we    = 1'b0;
        kmem_waddr = KA'(item_reg.key);
        kmem_wdata = '0;
        kmem_raddr = KA'(item.data.key);
        bmem_we    = 1'b0;
        bmem_waddr = AA'(item_reg.action);
        bmem_raddr = AA'(item.data.action);

        unique case (state_reg)
            // zero both memories after reset
            ksab_pkg::S_CLEAR:
            begin
                kmem_we    = 32'(sweep_reg) < 32'(KEY_COUNT);
                kmem_waddr = KA'(sweep_reg);
                bmem_we    = 32'(sweep_reg) < 32'(ACTION_COUNT);
                bmem_waddr = AA'(sweep_reg);
                sweep_next = sweep_reg + SWEEP_W'(1);
            end
            // take a request; the RAM reads start from the live payload
            ksab_pkg::S_IDLE:
            begin
                if (item_accept)
                begin
                    item_next  = item.data;
                    res_next   = '0;
                    sweep_next = '0;
                    scan_next  = '0;
                    if (item.data.opcode == ksab_pkg::OP_KEY_EVENT)
                        cur_mod_next = MW'(item.data.event_modifiers);
                end
            end
            // read data is here: modify and write back
            ksab_pkg::S_READ:
            begin
                row_key_next    = rd_key;
                row_mod_next    = rd_mod;
                res_next.status = status_c;
                bmem_we         = row_we;
                unique case (item_reg.opcode) inside
                    ksab_pkg::OP_KEY_EVENT:
                    begin
                        kmem_we = key_ok(item_reg.key);
                        if (item_reg.key_down)
                            kmem_wdata = {1'b1,
                                          kmem_rdata[F_PRESS] | ~kmem_rdata[F_HELD],
                                          kmem_rdata[F_REL]};
                        else
                            kmem_wdata = {1'b0, kmem_rdata[F_PRESS], 1'b1};
                    end
                    ksab_pkg::OP_QUERY:
                    begin
                        res_next.key_is_pressed =
                            key_ok(item_reg.key) & kmem_rdata[F_HELD];
                        res_next.key_was_just_pressed =
                            key_ok(item_reg.key) & kmem_rdata[F_PRESS];
                        res_next.key_was_just_released =
                            key_ok(item_reg.key) & kmem_rdata[F_REL];
                        kmem_raddr = KA'(rd_key[0]);
                        if (act_ok && slot_ok)
                        begin
                            res_next.slot_key       = rd_key[SW'(item_reg.slot)];
                            res_next.slot_modifiers =
                                ksab_pkg::MOD_W'(rd_mod[SW'(item_reg.slot)]);
                        end
                    end
                    default:
                    begin
                        kmem_we = 1'b0;
                    end
                endcase
            end
            // one slot per cycle: flags of this slot's key are on the RAM output
            ksab_pkg::S_SCAN:
            begin
                kmem_raddr = KA'(row_key_reg[scan_inc]);
                scan_next  = scan_inc;
                if (scan_key != '0)
                begin
                    res_next.action_is_bound = 1'b1;
                    if (key_ok(scan_key))
                    begin
                        if (kmem_rdata[F_HELD] &&
                            ksab_pkg::mod_match(mask_reg, ksab_pkg::MOD_W'(scan_mod),
                                                ksab_pkg::MOD_W'(cur_mod_reg)))
                            res_next.action_is_pressed = 1'b1;
                        if (kmem_rdata[F_PRESS] &&
                            ksab_pkg::mod_match(mask_reg, ksab_pkg::MOD_W'(scan_mod),
                                                ksab_pkg::MOD_W'(cur_mod_reg)))
                            res_next.action_just_pressed = 1'b1;
                        if (kmem_rdata[F_REL])
                            res_next.action_just_released = 1'b1;
                    end
                end
            end
            // edge flag sweep: read entry n, write back entry n-1 with edges cleared
            ksab_pkg::S_FRAME:
            begin
                kmem_raddr = KA'(sweep_reg);
                kmem_waddr = KA'(sweep_reg - SWEEP_W'(1));
                kmem_wdata = {kmem_rdata[F_HELD], 2'b00};
                kmem_we    = (sweep_reg != '0);
                if (sweep_reg != SWEEP_W'(KEY_COUNT))
                    sweep_next = sweep_reg + SWEEP_W'(1);
            end
            // hand the result to the output register
            ksab_pkg::S_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next               = res_reg;
                    out_data_next.modifiers_now = ksab_pkg::MOD_W'(cur_mod_reg);
                end
            end
            default:
            begin
                kmem_we = 1'b0;
                bmem_we = 1'b0;
            end
        endcase
    end

    // configuration writes
    always_comb
    begin
        mask_next = mask_reg;
        if (cfg_we)
            mask_next[cfg_index] = cfg_wdata;
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ksab_pkg::S_CLEAR;
            sweep_reg     <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
            cur_mod_reg   <= '0;
            mask_reg[ksab_pkg::CFG_CTRL]  <= ksab_pkg::CTRL_MASK_RST;
            mask_reg[ksab_pkg::CFG_SHIFT] <= ksab_pkg::SHIFT_MASK_RST;
            mask_reg[ksab_pkg::CFG_ALT]   <= ksab_pkg::ALT_MASK_RST;
            mask_reg[ksab_pkg::CFG_GUI]   <= ksab_pkg::GUI_MASK_RST;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
            cur_mod_reg   <= cur_mod_next;
            mask_reg      <= mask_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        row_key_reg  <= row_key_next;
        row_mod_reg  <= row_mod_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

`ifndef NO_ASSERTIONS
    // no result can appear before the memories are cleared
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ksab_pkg::S_CLEAR |-> !out_valid_reg)
        else $error("result valid during clearing pass");

    // a new result is only loaded from the emit step
    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ksab_pkg::S_EMIT))
        else $error("result valid rose outside emit");

    // both memories are written together only by the clearing pass
    a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        (kmem_we && bmem_we) |-> state_reg == ksab_pkg::S_CLEAR)
        else $error("key and binding RAM written in same cycle");

    // a query scan leaves only after the last slot
    a_scan_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ksab_pkg::S_SCAN && state_next != ksab_pkg::S_SCAN)
            |-> scan_reg == SW'(S - 1))
        else $error("slot scan ended early");
`endif

endmodule
